FILE: design/rmq_pkg.sv
// ============================================================================
// rmq_pkg: shared types and constants for the matrix to quaternion pipeline
// Widths of the radicand, root, divider and stage records, all derived from
// the data width and the fraction width of the fixed point format.
// ============================================================================
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    // Sum or difference of two elements
    localparam int A_W       = DATA_W + 1;
    // Unsigned radicand after clamping (covers 3 * 32767 + 2^FRAC_BITS)
    localparam int RAD_W     = (FRAC_BITS > 16) ? FRAC_BITS + 2 : 18;
    localparam int RS_W      = RAD_W + 1;
    // Root operand R * 2^FRAC_BITS and root width
    localparam int V_W       = RAD_W + FRAC_BITS;
    localparam int SW        = (V_W + 1) / 2;
    localparam int TW        = 2 * SW + 1;
    // Divider: divisor 2*S, numerator |A| * 2^FRAC_BITS, 16 quotient bits
    localparam int D_W       = SW + 1;
    localparam int Q_W       = DATA_W;
    localparam int NW        = A_W + FRAC_BITS;
    localparam int CW        = (NW > D_W + Q_W) ? NW : D_W + Q_W;

    // Component codes, also the slot index of each component
    typedef enum logic [1:0] {
        LEAD_X,
        LEAD_Y,
        LEAD_Z,
        LEAD_W
    } lead_t;

    // Per transaction payload carried through the root stages
    typedef struct packed {
        logic [3:0][A_W-1:0] a;
        lead_t               lead;
    } pl_t;

    // Per transaction control carried through the divider stages
    typedef struct packed {
        logic [SW-1:0] s;
        logic [3:0]    neg;
        logic [3:0]    ovf;
        lead_t         lead;
    } dctl_t;

    // Saturate a sign and magnitude quotient to 16 bits
    function automatic logic [Q_W-1:0] sat_q(input logic neg, input logic ovf,
                                             input logic [Q_W-1:0] q);
        logic [Q_W-1:0] res;
        if (!neg)
        begin
            res = (ovf || q[Q_W-1]) ? {1'b0, {(Q_W-1){1'b1}}} : q;
        end
        else
        begin
            if (ovf || (q > {1'b1, {(Q_W-1){1'b0}}}))
                res = {1'b1, {(Q_W-1){1'b0}}};
            else
                res = Q_W'(-q);
        end
        return res;
    endfunction

endpackage

FILE: design/rotation_matrix_to_quaternion.sv
// ============================================================================
// rotation_matrix_to_quaternion: pipelined rotation matrix to quaternion
// Trace method conversion in fixed point: pick the leading component, take
// a bit per stage square root, then a bit per stage division for the rest.
// ============================================================================
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid in_ready rot_00 .. rot_22   | into block
//  output  | out_valid out_ready quat_x .. quat_w | out of block
//
//  One transaction enters per cycle while in_ready is high; each one passes
//  through the SW root stages and 16 divider stages.
//  The whole pipeline advances together; a two entry output buffer lets one
//  more result leave the pipeline while a result waits, then holds the pipeline.
//  rst_n clears all valid bits; payload registers are not reset.
//
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] rot_00,
    input  logic signed [DATA_W-1:0] rot_01,
    input  logic signed [DATA_W-1:0] rot_02,
    input  logic signed [DATA_W-1:0] rot_10,
    input  logic signed [DATA_W-1:0] rot_11,
    input  logic signed [DATA_W-1:0] rot_12,
    input  logic signed [DATA_W-1:0] rot_20,
    input  logic signed [DATA_W-1:0] rot_21,
    input  logic signed [DATA_W-1:0] rot_22,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] quat_x,
    output logic signed [DATA_W-1:0] quat_y,
    output logic signed [DATA_W-1:0] quat_z,
    output logic signed [DATA_W-1:0] quat_w
);

    // ------------------------------------------------------------------
    // Global advance: the pipeline moves unless the output buffer is full
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Front end: trace, leading component, radicand, numerators
    // ------------------------------------------------------------------
    logic signed [A_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [A_W:0]   tr;
    logic signed [RS_W-1:0] rad;
    logic signed [RS_W-1:0] one;
    logic [RAD_W-1:0]      rad_u;
    lead_t                 h;
    pl_t                   prep_pl;

    always_comb
    begin
        e00 = A_W'(rot_00);
        e01 = A_W'(rot_01);
        e02 = A_W'(rot_02);
        e10 = A_W'(rot_10);
        e11 = A_W'(rot_11);
        e12 = A_W'(rot_12);
        e20 = A_W'(rot_20);
        e21 = A_W'(rot_21);
        e22 = A_W'(rot_22);
        one = RS_W'(1) <<< FRAC_BITS;
        tr  = (A_W+1)'(e00) + (A_W+1)'(e11) + (A_W+1)'(e22);

        // Ties keep the lower index; a zero trace takes the diagonal path
        if (tr > 0)
            h = LEAD_W;
        else if (rot_22 > ((rot_11 > rot_00) ? rot_11 : rot_00))
            h = LEAD_Z;
        else if (rot_11 > rot_00)
            h = LEAD_Y;
        else
            h = LEAD_X;

        prep_pl.lead = h;
        case (h)
            LEAD_X:
            begin
                rad = RS_W'(e00) - RS_W'(e11) - RS_W'(e22) + one;
                prep_pl.a[0] = '0;
                prep_pl.a[1] = A_W'(e10 + e01);
                prep_pl.a[2] = A_W'(e20 + e02);
                prep_pl.a[3] = A_W'(e21 - e12);
            end
            LEAD_Y:
            begin
                rad = RS_W'(e11) - RS_W'(e22) - RS_W'(e00) + one;
                prep_pl.a[0] = A_W'(e01 + e10);
                prep_pl.a[1] = '0;
                prep_pl.a[2] = A_W'(e21 + e12);
                prep_pl.a[3] = A_W'(e02 - e20);
            end
            LEAD_Z:
            begin
                rad = RS_W'(e22) - RS_W'(e00) - RS_W'(e11) + one;
                prep_pl.a[0] = A_W'(e02 + e20);
                prep_pl.a[1] = A_W'(e12 + e21);
                prep_pl.a[2] = '0;
                prep_pl.a[3] = A_W'(e10 - e01);
            end
            default:
            begin
                rad = RS_W'(tr) + one;
                prep_pl.a[0] = A_W'(e21 - e12);
                prep_pl.a[1] = A_W'(e02 - e20);
                prep_pl.a[2] = A_W'(e10 - e01);
                prep_pl.a[3] = '0;
            end
        endcase

        // Clamp a negative radicand to zero
        rad_u = rad[RS_W-1] ? '0 : rad[RAD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, remainder form
    // ------------------------------------------------------------------
    logic [TW-1:0] sq_rem_reg [SW];
    logic [SW-1:0] sq_r_reg   [SW];
    pl_t           sq_pl_reg  [SW];
    logic          sq_v_reg   [SW];
    logic [TW-1:0] sq_trial   [SW];
    logic [TW-1:0] sq_rem_n   [SW];
    logic [SW-1:0] sq_r_n     [SW];

    always_comb
    begin
        for (int k = 0; k < SW; k++)
        begin
            sq_trial[k] = (TW'(sq_r_reg[k]) << (SW - k)) | (TW'(1) << (2 * (SW - 1 - k)));
            if (sq_rem_reg[k] >= sq_trial[k])
            begin
                sq_rem_n[k] = sq_rem_reg[k] - sq_trial[k];
                sq_r_n[k]   = sq_r_reg[k] | (SW'(1) << (SW - 1 - k));
            end
            else
            begin
                sq_rem_n[k] = sq_rem_reg[k];
                sq_r_n[k]   = sq_r_reg[k];
            end
        end
    end

    logic [SW-1:0] rt_s_reg;
    pl_t           rt_pl_reg;
    logic          rt_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SW; k++)
                sq_v_reg[k] <= 1'b0;
            rt_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= in_valid;
            for (int k = 1; k < SW; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            rt_v_reg <= sq_v_reg[SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0] <= TW'(rad_u) << FRAC_BITS;
            sq_r_reg[0]   <= '0;
            sq_pl_reg[0]  <= prep_pl;
            for (int k = 1; k < SW; k++)
            begin
                sq_rem_reg[k] <= sq_rem_n[k-1];
                sq_r_reg[k]   <= sq_r_n[k-1];
                sq_pl_reg[k]  <= sq_pl_reg[k-1];
            end
            rt_s_reg  <= sq_r_n[SW-1];
            rt_pl_reg <= sq_pl_reg[SW-1];
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: sign, magnitude, overflow against 2*S << 16
    // ------------------------------------------------------------------
    logic [D_W-1:0]       su_d;
    logic [3:0][CW-1:0]   su_mag;
    logic [A_W-1:0]       su_abs [4];
    dctl_t                su_ctl;

    always_comb
    begin
        su_d         = {rt_s_reg, 1'b0};
        su_ctl.s     = rt_s_reg;
        su_ctl.lead  = rt_pl_reg.lead;
        for (int c = 0; c < 4; c++)
        begin
            su_ctl.neg[c] = rt_pl_reg.a[c][A_W-1];
            su_abs[c]     = su_ctl.neg[c] ? A_W'(-rt_pl_reg.a[c]) : rt_pl_reg.a[c];
            su_mag[c]     = CW'(su_abs[c]) << FRAC_BITS;
            su_ctl.ovf[c] = su_mag[c] >= (CW'(su_d) << Q_W);
        end
    end

    // ------------------------------------------------------------------
    // Restoring division: one quotient bit per stage, four lanes
    // ------------------------------------------------------------------
    logic [3:0][CW-1:0]  dv_rem_reg [Q_W];
    logic [3:0][Q_W-1:0] dv_q_reg   [Q_W+1];
    dctl_t               dv_ctl_reg [Q_W+1];
    logic                dv_v_reg   [Q_W+1];
    logic [CW-1:0]       dv_sub     [Q_W];
    logic [3:0][CW-1:0]  dv_rem_n   [Q_W];
    logic [3:0][Q_W-1:0] dv_q_n     [Q_W];

    always_comb
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            dv_sub[k] = CW'({dv_ctl_reg[k].s, 1'b0}) << (Q_W - 1 - k);
            for (int c = 0; c < 4; c++)
            begin
                if (dv_rem_reg[k][c] >= dv_sub[k])
                begin
                    dv_rem_n[k][c] = dv_rem_reg[k][c] - dv_sub[k];
                    dv_q_n[k][c]   = dv_q_reg[k][c] | (Q_W'(1) << (Q_W - 1 - k));
                end
                else
                begin
                    dv_rem_n[k][c] = dv_rem_reg[k][c];
                    dv_q_n[k][c]   = dv_q_reg[k][c];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Q_W; k++)
                dv_v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= rt_v_reg;
            for (int k = 1; k <= Q_W; k++)
                dv_v_reg[k] <= dv_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0] <= su_mag;
            dv_q_reg[0]   <= '0;
            dv_ctl_reg[0] <= su_ctl;
            for (int k = 1; k <= Q_W; k++)
            begin
                if (k < Q_W)
                    dv_rem_reg[k] <= dv_rem_n[k-1];
                dv_q_reg[k]   <= dv_q_n[k-1];
                dv_ctl_reg[k] <= dv_ctl_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Finish: leading component from S/2, others saturated, zero root
    // ------------------------------------------------------------------
    logic [3:0][DATA_W-1:0] fin_q;
    logic [SW-1:0]          fin_half;
    dctl_t                  fin_ctl;

    always_comb
    begin
        fin_ctl  = dv_ctl_reg[Q_W];
        fin_half = fin_ctl.s >> 1;
        for (int c = 0; c < 4; c++)
        begin
            if (fin_ctl.lead == lead_t'(2'(c)))
                fin_q[c] = (32'(fin_half) > 32'd32767) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                        : DATA_W'(fin_half);
            else if (fin_ctl.s == '0)
                fin_q[c] = '0;
            else
                fin_q[c] = sat_q(fin_ctl.neg[c], fin_ctl.ovf[c], dv_q_reg[Q_W][c]);
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid entry
    // ------------------------------------------------------------------
    logic [3:0][DATA_W-1:0] out_q_reg;
    logic [3:0][DATA_W-1:0] skid_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid entry into the output register
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (dv_v_reg[Q_W])
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_q_reg <= skid_q_reg;
        end
        else if (dv_v_reg[Q_W])
        begin
            if (out_valid_reg && !out_ready)
                skid_q_reg <= fin_q;
            else
                out_q_reg <= fin_q;
        end
    end

    assign out_valid = out_valid_reg;
    assign quat_x    = out_q_reg[LEAD_X];
    assign quat_y    = out_q_reg[LEAD_Y];
    assign quat_z    = out_q_reg[LEAD_Z];
    assign quat_w    = out_q_reg[LEAD_W];

endmodule
